FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/ccps_pkg.sv
// Types and constants of the constant pool scanner.
package ccps_pkg;

    localparam int SLOT_W    = 16;
    localparam int TAG_W     = 8;
    localparam int OUT_OFF_W = 24;
    localparam int LEN_W     = 17;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [OUT_OFF_W-1:0] OUT_OFF_MAX = '1;
    localparam logic [LEN_W-1:0]     LEN_MAX     = '1;

    // word index of the configuration registers (paddr[2])
    localparam logic REG_SLOT_COUNT = 1'b0;

    // constant pool tags
    localparam logic [TAG_W-1:0] TAG_UTF8       = 8'd1;
    localparam logic [TAG_W-1:0] TAG_INT        = 8'd3;
    localparam logic [TAG_W-1:0] TAG_FLOAT      = 8'd4;
    localparam logic [TAG_W-1:0] TAG_LONG       = 8'd5;
    localparam logic [TAG_W-1:0] TAG_DOUBLE     = 8'd6;
    localparam logic [TAG_W-1:0] TAG_CLASS      = 8'd7;
    localparam logic [TAG_W-1:0] TAG_STRING     = 8'd8;
    localparam logic [TAG_W-1:0] TAG_FIELDREF   = 8'd9;
    localparam logic [TAG_W-1:0] TAG_METHODREF  = 8'd10;
    localparam logic [TAG_W-1:0] TAG_IMETHODREF = 8'd11;
    localparam logic [TAG_W-1:0] TAG_NAMETYPE   = 8'd12;
    localparam logic [TAG_W-1:0] TAG_MHANDLE    = 8'd15;
    localparam logic [TAG_W-1:0] TAG_MTYPE      = 8'd16;
    localparam logic [TAG_W-1:0] TAG_INVDYN     = 8'd18;

    typedef struct packed {
        logic             start_req;
        logic [TAG_W-1:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [SLOT_W-1:0]    entry_index;
        logic [TAG_W-1:0]     entry_tag;
        logic [OUT_OFF_W-1:0] entry_offset;
        logic [LEN_W-1:0]     entry_length;
        logic                 pool_done;
        logic                 tag_error;
    } t_result;

endpackage

FILE: hdl/ccps_apb_regs.sv
// APB register block holding the slot count.
module ccps_apb_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [ccps_pkg::ADDR_W-1:0]         i_paddr,
    input  logic [ccps_pkg::DATA_W-1:0]         i_pwdata,
    output logic [ccps_pkg::DATA_W-1:0]         o_prdata,
    output logic                                o_pready,
    output logic [ccps_pkg::SLOT_W-1:0]         o_slot_count
);
    import ccps_pkg::*;

    logic [SLOT_W-1:0] r_slot_count;
    logic              w_wr;

    assign o_pready = 1'b1;
    assign w_wr     = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= '0;
        end else if (w_wr && i_paddr[2] == REG_SLOT_COUNT) begin
            r_slot_count <= i_pwdata[SLOT_W-1:0];
        end
    end

    always_comb begin
        unique case (i_paddr[2])
            REG_SLOT_COUNT: o_prdata = DATA_W'(r_slot_count);
            default:        o_prdata = '0;
        endcase
    end

    assign o_slot_count = r_slot_count;

endmodule

FILE: hdl/ccps_in_stage.sv
// Input register stage for incoming pool bytes.
module ccps_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ccps_pkg::t_in_word i_word,
    output logic               o_valid,
    input  logic               i_take,
    output ccps_pkg::t_in_word o_word
);
    import ccps_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    // free when empty or when the held word moves on this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

FILE: hdl/ccps_scan_core.sv
// Entry scanner: tag decode, counters and the result register.
module ccps_scan_core #(
    parameter int OFFSET_WIDTH = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [ccps_pkg::SLOT_W-1:0] i_slot_count,
    input  logic                        i_in_valid,
    input  ccps_pkg::t_in_word          i_in_word,
    output logic                        o_in_take,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output ccps_pkg::t_result           o_out
);
    import ccps_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_TAG, PH_LEN_HI, PH_LEN_LO, PH_BODY, PH_STOP
    } t_phase;

    localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = '1;
    localparam int WIDE = (OFFSET_WIDTH > OUT_OFF_W) ? OFFSET_WIDTH : OUT_OFF_W;

    // data bytes after the tag for fixed-size entries; zero for UTF-8 and bad tags
    function automatic logic [3:0] body_size(input logic [TAG_W-1:0] tag);
        case (tag) inside
            TAG_INT, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF,
            TAG_NAMETYPE, TAG_INVDYN:          body_size = 4'd4;
            TAG_LONG, TAG_DOUBLE:              body_size = 4'd8;
            TAG_CLASS, TAG_STRING, TAG_MTYPE:  body_size = 4'd2;
            TAG_MHANDLE:                       body_size = 4'd3;
            default:                           body_size = 4'd0;
        endcase
    endfunction

    t_phase                  r_phase, n_phase;
    logic [SLOT_W:0]         r_slot_index, n_slot_index;
    logic [OFFSET_WIDTH-1:0] r_byte_offset, n_byte_offset;
    logic [OFFSET_WIDTH-1:0] r_entry_start, n_entry_start;
    logic [TAG_W-1:0]        r_cur_tag, n_cur_tag;
    logic [SLOT_W-1:0]       r_bytes_left, n_bytes_left;
    logic [TAG_W-1:0]        r_len_high, n_len_high;
    logic                    r_out_valid, n_out_valid;
    t_result                 r_out, n_out;

    logic                    w_out_free;
    logic                    w_proc;
    logic [TAG_W-1:0]        w_byte;
    logic [OFFSET_WIDTH-1:0] w_here;
    logic [3:0]              w_size;
    logic [SLOT_W-1:0]       w_full_len;
    logic [SLOT_W-1:0]       w_left_dec;
    logic [SLOT_W+1:0]       w_next_slot;
    logic                    w_done;
    logic [OFFSET_WIDTH:0]   w_span;
    logic [LEN_W-1:0]        w_utf_len;
    logic [LEN_W-1:0]        w_fix_len;
    logic [WIDE-1:0]         w_start_ext;
    logic [OUT_OFF_W-1:0]    w_off_out;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_proc     = i_in_valid && w_out_free;
    assign o_in_take  = w_proc;
    assign w_byte     = i_in_word.data_byte;
    assign w_size     = body_size(w_byte);
    assign w_full_len = {r_len_high, w_byte};
    assign w_left_dec = (r_bytes_left != '0) ? r_bytes_left - 1'b1 : r_bytes_left;

    // offset of this byte; a start restarts the count at zero
    assign w_here = i_in_word.start_req ? '0 : r_byte_offset;

    assign w_next_slot = (r_cur_tag == TAG_LONG || r_cur_tag == TAG_DOUBLE)
                       ? {1'b0, r_slot_index} + (SLOT_W+2)'(2)
                       : {1'b0, r_slot_index} + (SLOT_W+2)'(1);
    assign w_done      = w_next_slot >= (SLOT_W+2)'(i_slot_count);

    assign w_span    = {1'b0, w_here} - {1'b0, r_entry_start} + (OFFSET_WIDTH+1)'(1);
    assign w_utf_len = (w_span > (OFFSET_WIDTH+1)'(LEN_MAX)) ? LEN_MAX : w_span[LEN_W-1:0];
    assign w_fix_len = LEN_W'(body_size(r_cur_tag)) + LEN_W'(1);

    assign w_start_ext = WIDE'(n_entry_start);
    assign w_off_out   = (w_start_ext > WIDE'(OUT_OFF_MAX)) ? OUT_OFF_MAX
                                                            : w_start_ext[OUT_OFF_W-1:0];

    always_comb begin
        n_phase       = r_phase;
        n_slot_index  = r_slot_index;
        n_byte_offset = r_byte_offset;
        n_entry_start = r_entry_start;
        n_cur_tag     = r_cur_tag;
        n_bytes_left  = r_bytes_left;
        n_len_high    = r_len_high;
        n_out_valid   = w_out_free ? 1'b0 : r_out_valid;
        n_out         = r_out;

        if (w_proc) begin
            if (i_in_word.start_req) begin
                n_slot_index  = '0;
                n_byte_offset = '0;
                n_bytes_left  = '0;
                n_len_high    = '0;
                n_phase       = (i_slot_count == '0) ? PH_STOP : PH_TAG;
            end

            if (n_phase == PH_TAG || n_phase == PH_LEN_HI
                    || n_phase == PH_LEN_LO || n_phase == PH_BODY) begin
                n_byte_offset = (w_here != OFF_MAX) ? w_here + 1'b1 : w_here;
                n_out.entry_index  = n_slot_index[SLOT_W-1:0];
                n_out.pool_done    = 1'b0;
                n_out.tag_error    = 1'b0;
                n_out.entry_length = LEN_W'(1);

                unique case (n_phase)
                    PH_TAG: begin
                        n_entry_start = w_here;
                        n_cur_tag     = w_byte;
                        if (w_byte == TAG_UTF8) begin
                            n_phase = PH_LEN_HI;
                        end else if (w_size == '0) begin
                            n_phase         = PH_STOP;
                            n_out_valid     = 1'b1;
                            n_out.tag_error = 1'b1;
                        end else begin
                            n_bytes_left = SLOT_W'(w_size);
                            n_phase      = PH_BODY;
                        end
                    end
                    PH_LEN_HI: begin
                        n_len_high = w_byte;
                        n_phase    = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        n_bytes_left = w_full_len;
                        if (w_full_len == '0) begin
                            n_out_valid        = 1'b1;
                            n_out.entry_length = LEN_W'(3);
                            n_out.pool_done    = w_done;
                            n_slot_index       = w_next_slot[SLOT_W:0];
                            n_phase            = w_done ? PH_STOP : PH_TAG;
                        end else begin
                            n_phase = PH_BODY;
                        end
                    end
                    default: begin
                        n_bytes_left = w_left_dec;
                        if (w_left_dec == '0) begin
                            n_out_valid        = 1'b1;
                            n_out.entry_length = (r_cur_tag == TAG_UTF8) ? w_utf_len
                                                                         : w_fix_len;
                            n_out.pool_done    = w_done;
                            n_slot_index       = w_next_slot[SLOT_W:0];
                            n_phase            = w_done ? PH_STOP : PH_TAG;
                        end
                    end
                endcase

                n_out.entry_tag    = n_cur_tag;
                n_out.entry_offset = w_off_out;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_slot_index  <= '0;
            r_byte_offset <= '0;
            r_entry_start <= '0;
            r_cur_tag     <= '0;
            r_bytes_left  <= '0;
            r_len_high    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_slot_index  <= n_slot_index;
            r_byte_offset <= n_byte_offset;
            r_entry_start <= n_entry_start;
            r_cur_tag     <= n_cur_tag;
            r_bytes_left  <= n_bytes_left;
            r_len_high    <= n_len_high;
            r_out_valid   <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: hdl/class_constant_pool_scanner_top.sv
// Top level of the class-file constant pool scanner.
//
//  port group   dir  word                                  accepted when
//  s_axis       in   tdata: data_byte; tuser: start_req   tvalid & tready
//  m_axis       out  tdata: entry fields; tlast: pool_done tvalid & tready
//                    tuser: tag_error
//  apb          in   slot_count at byte address 0          psel & penable & pwrite
//
// One byte a cycle is taken while no result word stalls; a result word is
// loaded into the result register as its last byte leaves the input register.
// Every byte, whether it completes an entry or not, waits while a result word
// sits unaccepted. Reset is synchronous; no clearing pass is needed after it.
// A stalled result holds in the result register; one more byte then waits in the
// input register before tready drops.
`include "assert_macros.svh"

module class_constant_pool_scanner_top #(
    parameter int OFFSET_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]                    i_s_axis_tuser,   // [0] start_req
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [15:0] entry_index, [23:16] entry_tag, [47:24] entry_offset,
    // [64:48] entry_length, [71:65] zero
    output logic [71:0]                   o_m_axis_tdata,
    output logic                          o_m_axis_tlast,   // pool_done
    output logic [0:0]                    o_m_axis_tuser,   // [0] tag_error
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [ccps_pkg::ADDR_W-1:0]   i_paddr,
    input  logic [ccps_pkg::DATA_W-1:0]   i_pwdata,
    output logic [ccps_pkg::DATA_W-1:0]   o_prdata,
    output logic                          o_pready
);
    import ccps_pkg::*;

    logic [SLOT_W-1:0] w_slot_count;
    t_in_word          w_in_word;
    t_in_word          w_stage_word;
    logic              w_stage_valid;
    logic              w_take;
    t_result           w_res;

    assign w_in_word.start_req = i_s_axis_tuser[0];
    assign w_in_word.data_byte = i_s_axis_tdata;

    ccps_apb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (i_psel),
        .i_penable    (i_penable),
        .i_pwrite     (i_pwrite),
        .i_paddr      (i_paddr),
        .i_pwdata     (i_pwdata),
        .o_prdata     (o_prdata),
        .o_pready     (o_pready),
        .o_slot_count (w_slot_count)
    );

    ccps_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_word  (w_in_word),
        .o_valid (w_stage_valid),
        .i_take  (w_take),
        .o_word  (w_stage_word)
    );

    ccps_scan_core #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_slot_count (w_slot_count),
        .i_in_valid   (w_stage_valid),
        .i_in_word    (w_stage_word),
        .o_in_take    (w_take),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_out        (w_res)
    );

    assign o_m_axis_tdata = {7'b0, w_res.entry_length, w_res.entry_offset,
                             w_res.entry_tag, w_res.entry_index};
    assign o_m_axis_tlast = w_res.pool_done;
    assign o_m_axis_tuser = w_res.tag_error;

    `ASSERT_IMPLIES(a_err_shape, i_clk, i_rst_n,
        o_m_axis_tvalid && w_res.tag_error,
        w_res.entry_length == LEN_W'(1) && !w_res.pool_done,
        "error word with bad length or done flag")
    `ASSERT_IMPLIES(a_ready_low, i_clk, i_rst_n,
        !o_s_axis_tready,
        w_stage_valid && o_m_axis_tvalid && !i_m_axis_tready,
        "input stalled without a result stall")
    `ASSERT_IMPLIES(a_fixed_len, i_clk, i_rst_n,
        o_m_axis_tvalid && w_res.entry_tag != TAG_UTF8,
        w_res.entry_length <= LEN_W'(9),
        "fixed-size entry longer than nine bytes")
    `ASSERT_NEXT(a_no_take_stall, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid,
        "result dropped while stalled")

endmodule
